@@ design/hds_pkg.sv @@
// ============================================================================
// hds_pkg
// shared types and constants of the heat diffusion stencil unit
// ============================================================================
package hds_pkg;

    // fixed field widths
    localparam int ROW_BITS      = 12;
    localparam int HEIGHT_BITS   = 13;
    localparam int RATE_BITS     = 16;
    localparam int RATE_FRAC     = 16;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // geometry limits
    localparam int MIN_DIM       = 3;
    localparam int MAX_HEIGHT    = 4096;

    // register reset values
    localparam int RST_GRID_WIDTH     = 100;
    localparam int RST_GRID_HEIGHT    = 100;
    localparam int RST_DIFFUSION_RATE = 6554;

    // front to back queue
    localparam int QUEUE_DEPTH   = 4;

    // register index on the config port
    typedef enum logic [1:0] {
        REG_GRID_WIDTH     = 2'd0,
        REG_GRID_HEIGHT    = 2'd1,
        REG_DIFFUSION_RATE = 2'd2
    } t_reg_idx;

    // classification of one cell as the front hands it to the back
    typedef struct packed {
        logic [ROW_BITS-1:0] row;      // row of the incoming cell
        logic                col_nz;   // column is not zero: window step and store update
        logic                last_col; // last column of the row
        logic                emit;     // a result comes out for the cell to the north-west
        logic                last;     // that result is the last interior cell
    } t_item_flags;

endpackage

@@ design/heat_diffusion_stencil_unit.sv @@
// ============================================================================
// heat_diffusion_stencil_unit
// five point laplacian stencil, one explicit heat step over a raster stream
// ============================================================================
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------------
//  in       | sink      | i_in_valid / o_in_ready | i_cell_temp, i_frame_start
//  out      | source    | o_out_valid / i_out_ready | o_new_temp, o_out_row, o_out_col, o_last
//  config   | apb slave | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
//  one cell is taken every clock cycle while the out side keeps up; the single
//  port write / single port read line store is touched once per cell
//  a result leaves after the cell that completes its window (its south-east
//  neighbour) has passed queue, store read, laplacian, product and output register
//  reset clears position, window control and all valid bits; the line store
//  keeps its contents, so no clearing pass is run and cells are taken at once
//  an out stall freezes the back pipeline; the front queue keeps taking cells
//  until its 4 entries are full, then o_in_ready drops
//
module heat_diffusion_stencil_unit #(
    parameter int MAX_WIDTH = 256,
    parameter int TEMP_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // cell input
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [TEMP_BITS-1:0]            i_cell_temp,
    input  logic                                   i_frame_start,

    // result output
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [TEMP_BITS-1:0]            o_new_temp,
    output logic [hds_pkg::ROW_BITS-1:0]           o_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_out_col,
    output logic                                   o_last,

    // register port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [hds_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [hds_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [hds_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready
);

    localparam int CB   = $clog2(MAX_WIDTH);
    localparam int WB   = $clog2(MAX_WIDTH + 1);
    localparam int HB   = hds_pkg::HEIGHT_BITS;
    localparam int DB   = hds_pkg::APB_DATA_BITS;
    localparam int FLGB = $bits(hds_pkg::t_item_flags);
    localparam int QW   = TEMP_BITS + CB + FLGB;

    // configuration registers
    logic [WB-1:0]                  r_grid_width;
    logic [HB-1:0]                  r_grid_height;
    logic [hds_pkg::RATE_BITS-1:0]  r_diffusion_rate;
    logic                           cfg_wr;
    hds_pkg::t_reg_idx              cfg_idx;

    // front to queue
    logic                  in_xfer;
    logic                  q_ready;
    logic [CB-1:0]         f_col;
    hds_pkg::t_item_flags  f_flags;
    logic [QW-1:0]         q_wdata;

    // queue to back
    logic                  q_valid;
    logic                  q_pop;
    logic [QW-1:0]         q_rdata;
    logic signed [TEMP_BITS-1:0] q_cell;
    logic [CB-1:0]         q_col;
    hds_pkg::t_item_flags  q_flags;

    // ------------------------------------------------------------------
    // register port: write in the access phase, zero wait states
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = hds_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width     <= WB'(hds_pkg::RST_GRID_WIDTH);
            r_grid_height    <= HB'(hds_pkg::RST_GRID_HEIGHT);
            r_diffusion_rate <= hds_pkg::RATE_BITS'(hds_pkg::RST_DIFFUSION_RATE);
        end else if (cfg_wr) begin
            case (cfg_idx)
                hds_pkg::REG_GRID_WIDTH: begin
                    r_grid_width <= pwdata[WB-1:0];
                end
                hds_pkg::REG_GRID_HEIGHT: begin
                    r_grid_height <= pwdata[HB-1:0];
                end
                hds_pkg::REG_DIFFUSION_RATE: begin
                    r_diffusion_rate <= pwdata[hds_pkg::RATE_BITS-1:0];
                end
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            hds_pkg::REG_GRID_WIDTH:     prdata = DB'(r_grid_width);
            hds_pkg::REG_GRID_HEIGHT:    prdata = DB'(r_grid_height);
            hds_pkg::REG_DIFFUSION_RATE: prdata = DB'(r_diffusion_rate);
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // front: position and classification, pushed straight into the queue
    // ------------------------------------------------------------------
    assign o_in_ready = q_ready;
    assign in_xfer    = i_in_valid && q_ready;

    hds_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_push        (in_xfer),
        .i_frame_start (i_frame_start),
        .o_col         (f_col),
        .o_flags       (f_flags)
    );

    assign q_wdata = {i_cell_temp, f_col, f_flags};

    // short queue so front and back stall on their own
    hds_queue #(
        .WIDTH (QW),
        .DEPTH (hds_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign q_cell  = q_rdata[QW-1:CB+FLGB];
    assign q_col   = q_rdata[CB+FLGB-1:FLGB];
    assign q_flags = q_rdata[FLGB-1:0];

    // ------------------------------------------------------------------
    // back: line store, window and update pipeline
    // ------------------------------------------------------------------
    hds_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .TEMP_BITS (TEMP_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rate      (r_diffusion_rate),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_cell    (q_cell),
        .i_q_col     (q_col),
        .i_q_flags   (q_flags),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_new_temp  (o_new_temp),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last)
    );

endmodule

@@ design/hds_ram.sv @@
// ============================================================================
// hds_ram
// generic single write port, single read port ram with registered read
// ============================================================================
module hds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/hds_queue.sv @@
// ============================================================================
// hds_queue
// small register fifo between the classifying front and the stencil back
// ============================================================================
module hds_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] n_count;

    assign o_ready = (r_count != CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // the top must never push into a full queue nor pop an empty one
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_ready) |-> i_pop)
        else $error("push into full queue");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

@@ design/hds_front.sv @@
// ============================================================================
// hds_front
// raster position tracking and classification of incoming cells
// ============================================================================
module hds_front #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       i_grid_width,
    input  logic [hds_pkg::HEIGHT_BITS-1:0]      i_grid_height,
    input  logic                                 i_push,
    input  logic                                 i_frame_start,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_col,
    output hds_pkg::t_item_flags                 o_flags
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int RB = hds_pkg::ROW_BITS;
    localparam int HB = hds_pkg::HEIGHT_BITS;

    logic [CB-1:0] r_col;
    logic [RB-1:0] r_row;
    logic [CB-1:0] n_col;
    logic [RB-1:0] n_row;

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic [CB-1:0] col_start;
    logic [RB-1:0] row_start;
    logic          wrap_col;
    logic [HB-1:0] row_ext;
    logic [CB-1:0] s_col;
    logic [RB-1:0] s_row;
    logic          last_col;
    logic          last_row;

    // clamp geometry to the supported range
    always_comb begin
        if (i_grid_width < WB'(hds_pkg::MIN_DIM)) begin
            w_eff = WB'(hds_pkg::MIN_DIM);
        end else if (i_grid_width > WB'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = i_grid_width;
        end
        if (i_grid_height < HB'(hds_pkg::MIN_DIM)) begin
            h_eff = HB'(hds_pkg::MIN_DIM);
        end else if (i_grid_height > HB'(hds_pkg::MAX_HEIGHT)) begin
            h_eff = HB'(hds_pkg::MAX_HEIGHT);
        end else begin
            h_eff = i_grid_height;
        end
    end

    // position of this cell, with wrap when the geometry shrank
    always_comb begin
        col_start = i_frame_start ? '0 : r_col;
        row_start = i_frame_start ? '0 : r_row;
        wrap_col  = (WB'(col_start) >= w_eff);
        row_ext   = {1'b0, row_start} + HB'(wrap_col);
        s_col     = wrap_col ? '0 : col_start;
        s_row     = (row_ext >= h_eff) ? '0 : row_ext[RB-1:0];
        last_col  = (WB'(s_col) == w_eff - WB'(1));
        last_row  = ({1'b0, s_row} == h_eff - HB'(1));
    end

    always_comb begin
        o_col            = s_col;
        o_flags.row      = s_row;
        o_flags.col_nz   = (s_col != '0);
        o_flags.last_col = last_col;
        o_flags.emit     = (s_row >= RB'(2)) && (s_col >= CB'(2));
        o_flags.last     = last_row && last_col;
    end

    // position of the next cell
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_push) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : s_row + RB'(1);
            end else begin
                n_col = s_col + CB'(1);
                n_row = s_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ design/hds_back.sv @@
// ============================================================================
// hds_back
// line stores, stencil window and the three stage update datapath
// ============================================================================
module hds_back #(
    parameter int MAX_WIDTH = 256,
    parameter int TEMP_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [hds_pkg::RATE_BITS-1:0]        i_rate,
    input  logic                                 i_q_valid,
    output logic                                 o_q_pop,
    input  logic signed [TEMP_BITS-1:0]          i_q_cell,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_q_col,
    input  hds_pkg::t_item_flags                 i_q_flags,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [TEMP_BITS-1:0]          o_new_temp,
    output logic [hds_pkg::ROW_BITS-1:0]         o_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_out_col,
    output logic                                 o_last
);

    localparam int T     = TEMP_BITS;
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int RB    = hds_pkg::ROW_BITS;
    localparam int LAP_B = T + 4;
    localparam int PRD_B = LAP_B + hds_pkg::RATE_BITS + 1;
    localparam int DLT_B = PRD_B - hds_pkg::RATE_FRAC;
    localparam int SUM_B = T + 6;

    logic en;

    // line store: {older row, previous row}
    logic            ram_we;
    logic [CB-1:0]   ram_waddr;
    logic [2*T-1:0]  ram_wdata;
    logic [2*T-1:0]  ram_rdata;

    // stage 1: store read data and window
    logic                 r1_valid;
    logic signed [T-1:0]  r1_cell;
    logic [CB-1:0]        r1_col;
    hds_pkg::t_item_flags r1_flags;
    logic                 r1_byp_hit;
    logic [2*T-1:0]       r1_byp_data;
    logic [2*T-1:0]       rd_eff;
    logic signed [T-1:0]  s_east;
    logic signed [T-1:0]  s_older;
    logic signed [LAP_B-1:0] s_lap;

    logic signed [T-1:0]  r_mid0;
    logic signed [T-1:0]  r_mid1;
    logic signed [T-1:0]  r_held;
    logic signed [T-1:0]  r_north;
    logic [CB-1:0]        r_pend_addr;
    logic                 r_pend_last;

    // stage 2: laplacian
    logic                    r2_valid;
    logic signed [LAP_B-1:0] r2_lap;
    logic signed [T-1:0]     r2_centre;
    logic [RB-1:0]           r2_row;
    logic [CB-1:0]           r2_col;
    logic                    r2_last;
    logic signed [hds_pkg::RATE_BITS:0] s_rate;

    // stage 3: product
    logic                    r3_valid;
    logic signed [PRD_B-1:0] r3_prod;
    logic signed [T-1:0]     r3_centre;
    logic [RB-1:0]           r3_row;
    logic [CB-1:0]           r3_col;
    logic                    r3_last;
    logic signed [DLT_B-1:0] s_delta;
    logic signed [SUM_B-1:0] s_sum;
    logic signed [T-1:0]     s_sat;

    // output register
    logic                 r_out_valid;
    logic signed [T-1:0]  r_out_temp;
    logic [RB-1:0]        r_out_row;
    logic [CB-1:0]        r_out_col;
    logic                 r_out_last;

    assign en      = !r_out_valid || i_out_ready;
    assign o_q_pop = en && i_q_valid;

    // the write of a column is held back one cell, as the window needs the old
    // older-row entry first; a row end write goes out with the next cell
    assign ram_we    = en && r1_valid && (r1_flags.col_nz || r_pend_last);
    assign ram_waddr = r_pend_addr;
    assign ram_wdata = {r_mid0, r_held};

    hds_ram #(
        .WIDTH (2 * T),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (o_q_pop),
        .i_raddr (i_q_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r1_cell     <= i_q_cell;
            r1_col      <= i_q_col;
            r1_flags    <= i_q_flags;
            // same cycle read and write of one entry
            r1_byp_hit  <= ram_we && (ram_waddr == i_q_col);
            r1_byp_data <= ram_wdata;
        end
    end

    always_comb begin
        rd_eff  = r1_byp_hit ? r1_byp_data : ram_rdata;
        s_east  = rd_eff[T-1:0];
        s_older = rd_eff[2*T-1:T];
        s_lap   = LAP_B'(r_north) + LAP_B'(r_held) + LAP_B'(s_east) + LAP_B'(r_mid1)
                - (LAP_B'(r_mid0) <<< 2);
    end

    // window shift on every cell that leaves stage 1
    always_ff @(posedge i_clk) begin
        if (en && r1_valid) begin
            r_mid1      <= r_mid0;
            r_mid0      <= s_east;
            r_held      <= r1_cell;
            r_north     <= s_older;
            r_pend_addr <= r1_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_last <= 1'b0;
        end else if (en && r1_valid) begin
            r_pend_last <= r1_flags.last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid && r1_flags.emit;
            r3_valid <= r2_valid;
        end
    end

    assign s_rate = {1'b0, i_rate};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_lap    <= s_lap;
            r2_centre <= r_mid0;
            r2_row    <= r1_flags.row - RB'(1);
            r2_col    <= r1_col - CB'(1);
            r2_last   <= r1_flags.last;
            r3_prod   <= r2_lap * s_rate;
            r3_centre <= r2_centre;
            r3_row    <= r2_row;
            r3_col    <= r2_col;
            r3_last   <= r2_last;
        end
    end

    // floor shift, add and saturate
    always_comb begin
        s_delta = r3_prod[PRD_B-1:hds_pkg::RATE_FRAC];
        s_sum   = SUM_B'(r3_centre) + SUM_B'(s_delta);
        if (!s_sum[SUM_B-1] && (|s_sum[SUM_B-2:T-1])) begin
            s_sat = {1'b0, {(T-1){1'b1}}};
        end else if (s_sum[SUM_B-1] && !(&s_sum[SUM_B-2:T-1])) begin
            s_sat = {1'b1, {(T-1){1'b0}}};
        end else begin
            s_sat = s_sum[T-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_temp <= s_sat;
            r_out_row  <= r3_row;
            r_out_col  <= r3_col;
            r_out_last <= r3_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_temp  = r_out_temp;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_last      = r_out_last;

    // a window step always follows the cell one column to the west
    a_pend_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && r1_flags.col_nz) |-> (r_pend_addr + CB'(1) == r1_col))
        else $error("window step without west neighbour");

    // a held row end write is always followed by column zero
    a_pend_last_col0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && r_pend_last) |-> !r1_flags.col_nz)
        else $error("row end write collides with a window step");

    // a stalled stage 1 keeps its line store data
    a_hold_rdata : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r1_valid) |=> $stable(ram_rdata))
        else $error("line store data lost under stall");

endmodule

@@ sim/tb_top.sv @@
// ============================================================================
// tb_top
// self-checking bench for the heat diffusion stencil unit
// ============================================================================
// cells are streamed in raster order over the valid/ready input and every
// transfer goes into a scoreboard. The scoreboard keeps its own line stores,
// window and position, so it knows which transfer completes an interior
// window and what the updated temperature must be. Each result transfer is
// compared field by field with the oldest pending update.
// A short directed part drives the saturation rails and the rounding toward
// minus infinity. A random part follows, made of phases: the geometry and
// rate registers are written over APB while the block is idle, then framed,
// wrapping, continuing or noisy cell streams are sent. Both sides idle at
// random. The out side also holds off once for a long stretch.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hds_pkg::*;

    localparam int MAX_W          = 256;
    localparam int TEMP_W         = 32;
    localparam int COL_BITS       = $clog2(MAX_W);
    localparam int WIDTH_REG_BITS = COL_BITS + 1;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 4;
    localparam int IDLE_PCT       = 37;
    localparam int DIRECTED_CELLS = 27;
    localparam int RANDOM_CELLS   = 1600;
    localparam int SETTLE_CYCLES  = 16;      // pipeline depth plus front queue, with margin
    localparam int QUIET_FROM     = 900;     // transfers in this range see no idling
    localparam int QUIET_TO       = 1200;
    localparam int HOLD_AT        = 400;     // out side holds off once past this count
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 250000;

    localparam longint TEMP_MAX = (longint'(1) <<< (TEMP_W - 1)) - 1;
    localparam longint TEMP_MIN = -TEMP_MAX - 1;
    localparam logic signed [TEMP_W-1:0] CELL_MAX = {1'b0, {(TEMP_W - 1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] CELL_MIN = {1'b1, {(TEMP_W - 1){1'b0}}};

    // how frame_start is placed inside one phase of the random part
    typedef enum int {
        STYLE_FRAMED,     // frame_start on the first cell of every frame
        STYLE_WRAP,       // frame_start once, later frames wrap on their own
        STYLE_CONTINUE,   // frame_start only if wider; carries on across the config change
        STYLE_NOISE       // stray frame_start pulses at random
    } t_phase_style;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [ROW_BITS-1:0]      row;
        logic [COL_BITS-1:0]      col;
        logic                     last;
    } t_cell_update;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the registers, the two line stores, the window
    // and the raster position; the pending updates come out in order
    // ------------------------------------------------------------------------
    class heat_step_scoreboard;
        int unsigned  grid_width;
        int unsigned  grid_height;
        int unsigned  diffusion_rate;
        longint       older_line [MAX_W];
        longint       prev_line [MAX_W];
        longint       window [2];
        longint       held_cell;
        int unsigned  col_pos;
        int unsigned  row_pos;
        t_cell_update pending_updates [$];
        int           fail_count;

        function new();
            grid_width     = RST_GRID_WIDTH;
            grid_height    = RST_GRID_HEIGHT;
            diffusion_rate = RST_DIFFUSION_RATE;
        endfunction

        function void set_reg(t_reg_idx idx, logic [APB_DATA_BITS-1:0] value);
            case (idx)
                REG_GRID_WIDTH:     grid_width     = value[WIDTH_REG_BITS-1:0];
                REG_GRID_HEIGHT:    grid_height    = value[HEIGHT_BITS-1:0];
                REG_DIFFUSION_RATE: diffusion_rate = value[RATE_BITS-1:0];
                default:            ;
            endcase
        endfunction

        function int unsigned active_width();
            if (grid_width < MIN_DIM) return MIN_DIM;
            if (grid_width > MAX_W) return MAX_W;
            return grid_width;
        endfunction

        function int unsigned active_height();
            if (grid_height < MIN_DIM) return MIN_DIM;
            if (grid_height > MAX_HEIGHT) return MAX_HEIGHT;
            return grid_height;
        endfunction

        function void note_cell(logic signed [TEMP_W-1:0] temp, logic frame_start);
            int unsigned  w;
            int unsigned  h;
            int unsigned  c;
            int unsigned  r;
            longint       east;
            longint       centre;
            longint       lap;
            longint       updated;
            t_cell_update upd;
            w = active_width();
            h = active_height();
            if (frame_start) begin
                col_pos = 0;
                row_pos = 0;
            end
            // a shrunk width or height wraps the position
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            c = col_pos;
            r = row_pos;

            east = prev_line[c];
            if (c >= 1) begin
                centre = window[0];
                if (r >= 2 && c >= 2) begin
                    lap = older_line[c - 1] + held_cell + east + window[1] - 4 * centre;
                    // the arithmetic shift floors the scaled laplacian
                    updated = centre + ((lap * longint'(diffusion_rate)) >>> RATE_FRAC);
                    if (updated > TEMP_MAX) updated = TEMP_MAX;
                    else if (updated < TEMP_MIN) updated = TEMP_MIN;
                    upd.temp = updated[TEMP_W-1:0];
                    upd.row  = ROW_BITS'(r - 1);
                    upd.col  = COL_BITS'(c - 1);
                    upd.last = (r == h - 1) && (c == w - 1);
                    pending_updates.push_back(upd);
                end
                older_line[c - 1] = centre;
                prev_line[c - 1]  = held_cell;
            end
            window[1] = window[0];
            window[0] = east;
            held_cell = temp;
            if (c == w - 1) begin
                older_line[c] = east;
                prev_line[c]  = temp;
            end

            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h) row_pos = 0;
            end
        endfunction

        function void check_update(logic signed [TEMP_W-1:0] temp, logic [ROW_BITS-1:0] row,
                                   logic [COL_BITS-1:0] col, logic last);
            t_cell_update exp_upd;
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected update, expected none, actual temp=%0d row=%0d col=%0d last=%0b",
                         $time, temp, row, col, last);
                fail_count++;
                return;
            end
            exp_upd = pending_updates.pop_front();
            if (temp !== exp_upd.temp) begin
                $display("%0t: new_temp mismatch, expected %0d, actual %0d",
                         $time, exp_upd.temp, temp);
                fail_count++;
            end
            if (row !== exp_upd.row) begin
                $display("%0t: out_row mismatch, expected %0d, actual %0d",
                         $time, exp_upd.row, row);
                fail_count++;
            end
            if (col !== exp_upd.col) begin
                $display("%0t: out_col mismatch, expected %0d, actual %0d",
                         $time, exp_upd.col, col);
                fail_count++;
            end
            if (last !== exp_upd.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, exp_upd.last, last);
                fail_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_in_valid    = 1'b0;
    logic                      o_in_ready;
    logic signed [TEMP_W-1:0]  i_cell_temp   = '0;
    logic                      i_frame_start = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready   = 1'b0;
    logic signed [TEMP_W-1:0]  o_new_temp;
    logic [ROW_BITS-1:0]       o_out_row;
    logic [COL_BITS-1:0]       o_out_col;
    logic                      o_last;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr         = '0;
    logic [APB_DATA_BITS-1:0]  pwdata        = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    heat_step_scoreboard sb;
    int                  cells_accepted = 0;
    bit                  settling       = 1'b0;   // out side keeps ready high while set

    heat_diffusion_stencil_unit #(
        .MAX_WIDTH (MAX_W),
        .TEMP_BITS (TEMP_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cell_temp   (i_cell_temp),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_new_temp    (o_new_temp),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // stretch of transfers in which neither side idles
    function automatic bit no_idle_stretch();
        return cells_accepted >= QUIET_FROM && cells_accepted < QUIET_TO;
    endfunction

    // mix of rails, full range noise and realistic values near zero
    function automatic logic signed [TEMP_W-1:0] random_temp();
        logic [31:0] bits;
        int unsigned sel;
        bits = $urandom();
        sel  = $urandom_range(99);
        if (sel < 8) return bits[0] ? CELL_MAX : CELL_MIN;
        if (sel < 40) return TEMP_W'(bits);
        return TEMP_W'($signed(bits[20:0]));
    endfunction

    // one cell transfer; valid stays high into the next cell when no gap is drawn
    task automatic send_cell(input logic signed [TEMP_W-1:0] temp, input logic frame_start);
        while (!no_idle_stretch() && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cell_temp   <= temp;
        i_frame_start <= frame_start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_cell(temp, frame_start);
        cells_accepted++;
    endtask

    // setup and access phase per register, psel held across the three writes
    task automatic program_grid(input logic [APB_DATA_BITS-1:0] width_val,
                                input logic [APB_DATA_BITS-1:0] height_val,
                                input logic [APB_DATA_BITS-1:0] rate_val);
        logic [APB_DATA_BITS-1:0] vals [3];
        t_reg_idx                 idx;
        vals[0] = width_val;
        vals[1] = height_val;
        vals[2] = rate_val;
        for (int i = 0; i < 3; i++) begin
            idx = t_reg_idx'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_ADDR_BITS'({idx, 2'b00});
            pwdata  <= vals[i];
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            sb.set_reg(idx, vals[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // all pending updates out, then let cells without a result leave the pipe
    task automatic settle();
        while (sb.pending_updates.size() != 0) @(posedge i_clk);
        settling = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        settling = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // out side: check each result transfer, drive ready with random stalls
    // and one long hold-off that backs the stream up to the input
    // ------------------------------------------------------------------------
    initial begin : out_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_update(o_new_temp, o_out_row, o_out_col, o_last);
            if (!hold_done && cells_accepted >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (settling || no_idle_stretch()) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus: directed frames, then random phases
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned  phase_no;
        int unsigned  n;
        int unsigned  w;
        int unsigned  h;
        int unsigned  area;
        int unsigned  prev_w;
        int unsigned  sel;
        int unsigned  raw_w;
        int unsigned  raw_h;
        int unsigned  raw_rate;
        int unsigned  remaining;
        bit           force_start;
        logic         fs;
        t_phase_style style;
        logic signed [TEMP_W-1:0] temp;

        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest grid through the clamp (width 2, height 0) and the largest rate;
        // first frame pushes the sum past the top rail, the second wraps in
        // without frame_start and goes past the bottom rail, the third checks
        // that a small negative laplacian rounds down
        program_grid(2, 0, 16'hFFFF);
        for (int f = 0; f < 3; f++) begin
            for (int k = 0; k < 9; k++) begin
                if (k == 4)
                    temp = (f == 0) ? CELL_MIN : (f == 1) ? CELL_MAX : TEMP_W'(1);
                else if (k % 2 == 1)
                    temp = (f == 0) ? CELL_MAX : (f == 1) ? CELL_MIN : TEMP_W'(0);
                else
                    temp = random_temp();
                send_cell(temp, (k == 0) && (f != 1));
            end
        end
        i_in_valid <= 1'b0;
        prev_w   = sb.active_width();
        phase_no = 0;

        while (cells_accepted < DIRECTED_CELLS + RANDOM_CELLS) begin
            settle();
            if (phase_no == 0) begin
                // widest grid through the clamp, three rows, no diffusion
                raw_w    = 511;
                raw_h    = 3;
                raw_rate = 0;
            end else if (phase_no == 1) begin
                // narrowest and tallest through the clamp, smallest nonzero rate
                raw_w    = 0;
                raw_h    = 8191;
                raw_rate = 1;
            end else begin
                sel = $urandom_range(99);
                if (sel < 60)      raw_w = $urandom_range(10, 3);
                else if (sel < 70) raw_w = $urandom_range(2, 0);
                else if (sel < 85) raw_w = $urandom_range(40, 11);
                else if (sel < 90) raw_w = MAX_W;
                else if (sel < 94) raw_w = $urandom_range(511, MAX_W + 1);
                else               raw_w = $urandom_range(MAX_W - 1, 200);
                sel = $urandom_range(99);
                if (sel < 60)      raw_h = $urandom_range(8, 3);
                else if (sel < 70) raw_h = $urandom_range(2, 0);
                else if (sel < 80) raw_h = $urandom_range(30, 9);
                else if (sel < 86) raw_h = MAX_HEIGHT;
                else if (sel < 92) raw_h = $urandom_range(8191, MAX_HEIGHT + 1);
                else               raw_h = $urandom_range(MAX_HEIGHT - 1, 100);
                sel = $urandom_range(99);
                if (sel < 15)      raw_rate = 0;
                else if (sel < 30) raw_rate = 16'hFFFF;
                else               raw_rate = $urandom_range(16'hFFFF, 0);
            end
            program_grid(raw_w, raw_h, raw_rate);
            w    = sb.active_width();
            h    = sb.active_height();
            area = w * h;

            // a wider row inside a frame would read store entries never written
            force_start = (w > prev_w);
            prev_w      = w;

            sel = $urandom_range(99);
            if (phase_no == 0 || sel < 55) style = STYLE_FRAMED;
            else if (sel < 70)             style = STYLE_WRAP;
            else if (sel < 85)             style = STYLE_CONTINUE;
            else                           style = STYLE_NOISE;

            if (phase_no == 0)
                n = area;
            else if (area <= 200)
                n = area * $urandom_range(3, 1)
                    + (($urandom_range(3) == 0) ? $urandom_range(area - 1, 0) : 0);
            else
                n = $urandom_range(2 * w + 200, 40);

            // the last phase stops at the cell budget
            remaining = DIRECTED_CELLS + RANDOM_CELLS - cells_accepted;
            if (n > remaining) n = remaining;

            for (int i = 0; i < n; i++) begin
                case (style)
                    STYLE_FRAMED:   fs = (i % area == 0);
                    STYLE_WRAP:     fs = (i == 0);
                    STYLE_CONTINUE: fs = force_start && (i == 0);
                    default:        fs = (force_start && (i == 0)) || ($urandom_range(24) == 0);
                endcase
                send_cell(random_temp(), fs);
            end
            i_in_valid <= 1'b0;
            phase_no++;
        end

        settle();
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

endmodule
